FILE: rtl/vlmr_pkg.sv
// ----------------------------------------------------------------------------
// vlmr_pkg
// shared constants and codes of the variable-length message ring
// ----------------------------------------------------------------------------
package vlmr_pkg;

	localparam int CAPACITY_BYTES = 4096;
	localparam int LEN_BYTES      = 4;

	localparam int ADDR_W    = $clog2(CAPACITY_BYTES);
	localparam int POS_W     = ADDR_W + 1;
	localparam int HDR_BYTES = 1 + LEN_BYTES;
	// only the low twelve bits of a stored length are ever used
	localparam int LEN_RD    = (LEN_BYTES < 2) ? 1 : 2;
	localparam int CNT_W     = $clog2(HDR_BYTES);
	localparam int OCC_W     = POS_W + 2;

	localparam logic [7:0] ST_NOT_READY = 8'd0;
	localparam logic [7:0] ST_READY     = 8'd1;
	localparam logic [7:0] ST_FREED     = 8'd3;

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		REQ_PUSH_BEGIN = 2'd0,
		REQ_PUSH_BYTE  = 2'd1,
		REQ_POP_BEGIN  = 2'd2,
		REQ_POP_BYTE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_BUSY     = 3'd3,
		STAT_SEQ_ERR  = 3'd4
	} stat_t;

endpackage

FILE: rtl/vlmr_ram.sv
// ----------------------------------------------------------------------------
// vlmr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module vlmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/variable_length_message_ring_unit.sv
// ----------------------------------------------------------------------------
// variable_length_message_ring_unit
// byte ring of variable-length records (status, length, payload)
// ----------------------------------------------------------------------------
// latency to result strobe depends on the request: errors and push_byte answer directly, but
//   a byte ending a message first marks its record ready; pop_byte waits on its ram read;
//   push_begin writes the header; pop_begin reads status and length, skipping one freed
//   record if found; throughput: one request in flight, busy until its result
// reset: pointers, counts and open flags cleared at once; ring contents are not cleared; the
//   one-cycle result strobe done cannot be held off by the receiver
module variable_length_message_ring_unit
	import vlmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [11:0] msg_len,
	input  logic [7:0]  data_byte,
	output logic        done,
	output logic [2:0]  status,
	output logic [11:0] read_len,
	output logic [7:0]  read_byte,
	output logic        last_byte
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PB_HDR,   // writing record header bytes
		S_PY_RDY,   // marking the pushed record ready
		S_PO_CHK,   // head against tail, read head status
		S_PO_ST,    // status byte returns
		S_PO_LEN,   // length bytes return
		S_PR_WAIT   // payload byte returns
	} state_t;

	state_t state_q;

	// ring pointers
	pos_t        head_q, tail_q;
	pos_t        prec_q, pwr_q;
	logic [11:0] prem_q;
	logic        popen_q;
	pos_t        prd_q;
	logic [11:0] qrem_q;
	logic        qopen_q;

	// per-request working registers
	pos_t             rec_q;
	logic [11:0]      len_q;
	logic [CNT_W-1:0] cnt_q;
	logic             skip_q;     // current head record is freed and being skipped
	logic             skipped_q;  // one freed record already reclaimed

	logic        done_q, last_q;
	logic [2:0]  status_q;
	logic [11:0] read_len_q;
	logic [7:0]  read_byte_q;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	logic              accept;
	req_t              req;
	logic [POS_W-1:0]  occ;
	logic [OCC_W-1:0]  need;
	logic              fits;
	logic [11:0]       len_nx;
	logic [7:0]        hdr_byte;
	logic [CNT_W-1:0]  lidx;
	pos_t              hdr_pos, lrd_pos;

	assign accept = start && (state_q == S_IDLE);
	assign req    = req_t'(req_type);
	assign busy   = (state_q != S_IDLE);

	// occupancy includes freed records not yet reclaimed
	assign occ  = POS_W'(tail_q - head_q);
	assign need = OCC_W'(occ) + OCC_W'(msg_len) + OCC_W'(HDR_BYTES);
	assign fits = (LEN_BYTES >= 2) || (msg_len[11:8] == 4'd0);

	// header byte for the push being written, little-endian length
	assign lidx = CNT_W'(cnt_q - CNT_W'(1));
	always_comb begin
		if (cnt_q == '0) begin
			hdr_byte = (len_q == 12'd0) ? ST_READY : ST_NOT_READY;
		end else if (lidx == CNT_W'(0)) begin
			hdr_byte = len_q[7:0];
		end else if (lidx == CNT_W'(1)) begin
			hdr_byte = {4'd0, len_q[11:8]};
		end else begin
			hdr_byte = 8'd0;
		end
	end

	// length assembled from the byte now returning
	assign len_nx = (cnt_q == CNT_W'(1)) ? {len_q[11:8], ram_rdata}
	                                     : {ram_rdata[3:0], len_q[7:0]};

	assign hdr_pos = POS_W'(rec_q + POS_W'(cnt_q));
	assign lrd_pos = POS_W'(rec_q + POS_W'(1) + POS_W'(cnt_q));

	// ram address and write selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pwr_q[ADDR_W-1:0];
		ram_wdata = data_byte;
		ram_raddr = lrd_pos[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = prd_q[ADDR_W-1:0];
				ram_we    = accept && (req == REQ_PUSH_BYTE) && popen_q;
			end
			S_PB_HDR: begin
				ram_we    = 1'b1;
				ram_waddr = hdr_pos[ADDR_W-1:0];
				ram_wdata = hdr_byte;
			end
			S_PY_RDY: begin
				ram_we    = 1'b1;
				ram_waddr = prec_q[ADDR_W-1:0];
				ram_wdata = ST_READY;
			end
			S_PO_CHK: begin
				ram_raddr = head_q[ADDR_W-1:0];
			end
			S_PO_LEN: begin
				// popped record is marked freed as its length completes
				ram_we    = (cnt_q == CNT_W'(LEN_RD)) && !skip_q;
				ram_waddr = rec_q[ADDR_W-1:0];
				ram_wdata = ST_FREED;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	vlmr_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY_BYTES)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// request sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			prec_q      <= '0;
			pwr_q       <= '0;
			prem_q      <= '0;
			popen_q     <= 1'b0;
			prd_q       <= '0;
			qrem_q      <= '0;
			qopen_q     <= 1'b0;
			rec_q       <= '0;
			len_q       <= '0;
			skip_q      <= 1'b0;
			skipped_q   <= 1'b0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			status_q    <= '0;
			read_len_q  <= '0;
			read_byte_q <= '0;
			last_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// default result, overridden where the request takes longer
						done_q      <= 1'b1;
						status_q    <= STAT_OK;
						read_len_q  <= '0;
						read_byte_q <= '0;
						last_q      <= 1'b0;
						unique case (req)
							REQ_PUSH_BEGIN: begin
								if (popen_q) begin
									status_q <= STAT_SEQ_ERR;
								end else if (!fits ||
										need > OCC_W'(CAPACITY_BYTES - 1)) begin
									status_q <= STAT_FULL;
								end else begin
									done_q  <= 1'b0;
									rec_q   <= tail_q;
									len_q   <= msg_len;
									cnt_q   <= '0;
									state_q <= S_PB_HDR;
								end
							end
							REQ_PUSH_BYTE: begin
								if (!popen_q) begin
									status_q <= STAT_SEQ_ERR;
								end else begin
									pwr_q  <= POS_W'(pwr_q + POS_W'(1));
									prem_q <= prem_q - 12'd1;
									if (prem_q == 12'd1) begin
										done_q  <= 1'b0;
										popen_q <= 1'b0;
										state_q <= S_PY_RDY;
									end
								end
							end
							REQ_POP_BEGIN: begin
								if (qopen_q) begin
									status_q <= STAT_SEQ_ERR;
								end else begin
									done_q    <= 1'b0;
									skipped_q <= 1'b0;
									state_q   <= S_PO_CHK;
								end
							end
							REQ_POP_BYTE: begin
								if (!qopen_q) begin
									status_q <= STAT_SEQ_ERR;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_PR_WAIT;
								end
							end
							default: begin
								status_q <= STAT_SEQ_ERR;
							end
						endcase
					end
				end
				S_PB_HDR: begin
					cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
					if (cnt_q == CNT_W'(HDR_BYTES - 1)) begin
						tail_q  <= POS_W'(tail_q + POS_W'(HDR_BYTES) + POS_W'(len_q));
						prec_q  <= rec_q;
						pwr_q   <= POS_W'(rec_q + POS_W'(HDR_BYTES));
						prem_q  <= len_q;
						popen_q <= (len_q != 12'd0);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_PY_RDY: begin
					done_q  <= 1'b1;
					last_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PO_CHK: begin
					if (tail_q == head_q) begin
						done_q   <= 1'b1;
						status_q <= STAT_EMPTY;
						state_q  <= S_IDLE;
					end else begin
						// first length byte is read while the status byte returns
						rec_q   <= head_q;
						cnt_q   <= '0;
						state_q <= S_PO_ST;
					end
				end
				S_PO_ST: begin
					len_q <= '0;
					cnt_q <= CNT_W'(1);
					if ((ram_rdata == ST_FREED) && !skipped_q) begin
						skip_q  <= 1'b1;
						state_q <= S_PO_LEN;
					end else if (ram_rdata != ST_READY) begin
						done_q   <= 1'b1;
						status_q <= STAT_BUSY;
						state_q  <= S_IDLE;
					end else begin
						skip_q  <= 1'b0;
						state_q <= S_PO_LEN;
					end
				end
				S_PO_LEN: begin
					len_q <= len_nx;
					cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
					if (cnt_q == CNT_W'(LEN_RD)) begin
						if (skip_q) begin
							// reclaim the freed record and look at the next one
							head_q    <= POS_W'(rec_q + POS_W'(HDR_BYTES) + POS_W'(len_nx));
							skipped_q <= 1'b1;
							state_q   <= S_PO_CHK;
						end else begin
							prd_q      <= POS_W'(rec_q + POS_W'(HDR_BYTES));
							qrem_q     <= len_nx;
							qopen_q    <= (len_nx != 12'd0);
							done_q     <= 1'b1;
							read_len_q <= len_nx;
							state_q    <= S_IDLE;
						end
					end
				end
				S_PR_WAIT: begin
					read_byte_q <= ram_rdata;
					prd_q       <= POS_W'(prd_q + POS_W'(1));
					qrem_q      <= qrem_q - 12'd1;
					if (qrem_q == 12'd1) begin
						qopen_q <= 1'b0;
						last_q  <= 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign read_len  = read_len_q;
	assign read_byte = read_byte_q;
	assign last_byte = last_q;

`ifndef SYNTHESIS
	// an accepted request either answers at once or keeps the unit busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither answered nor in progress");

	// an open push always has bytes outstanding
	assert property (@(posedge clk) disable iff (!arst_n)
		popen_q |-> (prem_q != 12'd0))
		else $error("push open with nothing remaining");

	// an open pop always has bytes outstanding
	assert property (@(posedge clk) disable iff (!arst_n)
		qopen_q |-> (qrem_q != 12'd0))
		else $error("pop open with nothing remaining");

	// reserved space never exceeds the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		occ <= POS_W'(CAPACITY_BYTES - 1))
		else $error("ring occupancy beyond capacity");

	// failed requests carry no length and no end mark
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> ((read_len == 12'd0) && !last_byte))
		else $error("error result with payload fields set");
`endif

endmodule
